// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; they expand to nothing in synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clock, reset, prop, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clock, reset, expr, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`else

`define ASSERT_AT(lbl, clock, reset, prop, msg)
`define ASSERT_NEVER(lbl, clock, reset, expr, msg)

`endif

`endif

// ----- sv/sic_pkg.sv -----
// ----------------------------------------------------------------------------
// sic_pkg
// Codes, widths and helpers for the simplified interrupt controller
// ----------------------------------------------------------------------------
package sic_pkg;

  // transaction kinds carried in tuser
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_LINE  = 2'd2;

  // port selector
  localparam logic PORT_CMD  = 1'b0;
  localparam logic PORT_DATA = 1'b1;

  // command byte decode bits
  localparam int unsigned ICW1_BIT   = 4;
  localparam int unsigned OCW3_BIT   = 3;
  localparam int unsigned POLL_BIT   = 2;
  localparam int unsigned RSEL_EN    = 1;
  localparam int unsigned RSEL_BIT   = 0;

  // OCW2 command codes in bits 7..5
  localparam logic [2:0] OCW2_EOI_NS    = 3'd1;
  localparam logic [2:0] OCW2_EOI_SPEC  = 3'd3;
  localparam logic [2:0] OCW2_ROT_NS    = 3'd5;
  localparam logic [2:0] OCW2_ROT_SPEC  = 3'd7;

  // initialization word counter values
  localparam logic [1:0] IWC_IDLE = 2'd0;
  localparam logic [1:0] IWC_ICW2 = 2'd1;
  localparam logic [1:0] IWC_LAST = 2'd3;

  localparam logic [7:0] MASK_ALL   = 8'hFF;
  localparam logic       POLL_FLAG  = 1'b1;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 16;

  // lowest set bit index; 7 when none is set
  function automatic logic [2:0] lowest_index(input logic [7:0] v);
    logic [2:0] n;
    n = 3'd7;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) n = 3'(i);
    end
    return n;
  endfunction

endpackage

// ----- sv/simplified_interrupt_controller_unit.sv -----
// ----------------------------------------------------------------------------
// simplified_interrupt_controller_unit
// Reduced 8-line interrupt controller driven by a stream of port reads,
// port writes and line level changes, one result per transaction
// ----------------------------------------------------------------------------
//  channel   direction  tdata                               tuser
//  s_axis    in         wdata[7:0] line_number[10:8]        action[1:0]
//                       line_level[11]                      port[2]
//  m_axis    out        rdata[7:0] irq_out[8]               -
//
// One transaction per cycle while s_tready is high; the state update and the result
// are computed combinationally from the controller registers and land in the output stage.
// A two-entry output stage (output register plus skid register) keeps input
// accepted while one result waits; s_tready drops only when both are full.
// rst is synchronous and clears all controller state and both output entries.
`include "assert_macros.svh"

module simplified_interrupt_controller_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // wdata[7:0], line_number[10:8], line_level[11], zero fill above
  input  logic [sic_pkg::IN_DATA_W-1:0]     s_tdata,
  // action[1:0], port[2]
  input  logic [sic_pkg::IN_USER_W-1:0]     s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // rdata[7:0], irq_out[8], zero fill above
  output logic [sic_pkg::OUT_DATA_W-1:0]    m_tdata
);

  // controller state
  logic [7:0] request_bits, request_bits_next;
  logic [7:0] service_bits, service_bits_next;
  logic [7:0] mask_bits, mask_bits_next;
  logic [1:0] init_word_count, init_word_count_next;
  logic       poll_pending, poll_pending_next;
  logic       select_service, select_service_next;
  logic       output_level, output_level_next;

  // output stage
  logic       out_valid, skid_valid;
  logic [8:0] out_data, skid_data;

  // item fields
  logic [1:0] action;
  logic       port;
  logic [7:0] wdata;
  logic [2:0] line_number;
  logic       line_level;

  logic       acc, take, recompute;
  logic [7:0] ready_bits, rdata_c;
  logic [2:0] poll_line, cmd;

  assign action      = s_tuser[1:0];
  assign port        = s_tuser[2];
  assign wdata       = s_tdata[7:0];
  assign line_number = s_tdata[10:8];
  assign line_level  = s_tdata[11];

  assign s_tready = !skid_valid;
  assign acc      = s_tvalid && s_tready;
  assign take     = out_valid && m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(sic_pkg::OUT_DATA_W-9){1'b0}}, out_data};

  assign ready_bits = request_bits & ~mask_bits;
  assign poll_line  = sic_pkg::lowest_index(ready_bits);
  assign cmd        = wdata[7:5];

  // next state and read data for the current transaction
  always_comb begin
    request_bits_next    = request_bits;
    service_bits_next    = service_bits;
    mask_bits_next       = mask_bits;
    init_word_count_next = init_word_count;
    poll_pending_next    = poll_pending;
    select_service_next  = select_service;
    recompute            = 1'b0;
    rdata_c              = 8'h00;
    unique case (action)
      sic_pkg::ACT_READ: begin
        if (port == sic_pkg::PORT_DATA) begin
          rdata_c = mask_bits;
        end else if (poll_pending) begin
          poll_pending_next = 1'b0;
          if (ready_bits != 8'h00) begin
            service_bits_next = service_bits | (8'b1 << poll_line);
            request_bits_next = request_bits & ~(8'b1 << poll_line);
            rdata_c           = {1'b1, 4'b0000, poll_line};
          end
        end else begin
          rdata_c = select_service ? service_bits : request_bits;
        end
      end
      sic_pkg::ACT_WRITE: begin
        if (port == sic_pkg::PORT_DATA) begin
          if (init_word_count != sic_pkg::IWC_IDLE) begin
            init_word_count_next = (init_word_count == sic_pkg::IWC_LAST)
                                   ? sic_pkg::IWC_IDLE : init_word_count + 2'd1;
          end else begin
            mask_bits_next = wdata;
            recompute      = 1'b1;
          end
        end else if (wdata[sic_pkg::ICW1_BIT]) begin
          // ICW1 restarts the controller
          init_word_count_next = sic_pkg::IWC_ICW2;
          mask_bits_next       = sic_pkg::MASK_ALL;
          request_bits_next    = 8'h00;
          service_bits_next    = 8'h00;
          poll_pending_next    = 1'b0;
        end else if (wdata[sic_pkg::OCW3_BIT]) begin
          if (wdata[sic_pkg::POLL_BIT]) poll_pending_next = sic_pkg::POLL_FLAG;
          if (wdata[sic_pkg::RSEL_EN]) select_service_next = wdata[sic_pkg::RSEL_BIT];
        end else begin
          // OCW2 end of interrupt
          if (cmd == sic_pkg::OCW2_EOI_NS || cmd == sic_pkg::OCW2_ROT_NS) begin
            service_bits_next = service_bits & (service_bits - 8'd1);
          end else if (cmd == sic_pkg::OCW2_EOI_SPEC || cmd == sic_pkg::OCW2_ROT_SPEC) begin
            service_bits_next = service_bits & ~(8'b1 << wdata[2:0]);
          end
          recompute = 1'b1;
        end
      end
      sic_pkg::ACT_LINE: begin
        request_bits_next[line_number] = line_level;
        recompute                      = 1'b1;
      end
      default: begin
      end
    endcase
    output_level_next = recompute
                        ? |(request_bits_next & ~mask_bits_next & ~service_bits_next)
                        : output_level;
  end

  // controller registers
  always_ff @(posedge clk) begin
    if (rst) begin
      request_bits    <= 8'h00;
      service_bits    <= 8'h00;
      mask_bits       <= 8'h00;
      init_word_count <= sic_pkg::IWC_IDLE;
      poll_pending    <= 1'b0;
      select_service  <= 1'b0;
      output_level    <= 1'b0;
    end else if (acc) begin
      request_bits    <= request_bits_next;
      service_bits    <= service_bits_next;
      mask_bits       <= mask_bits_next;
      init_word_count <= init_word_count_next;
      poll_pending    <= poll_pending_next;
      select_service  <= select_service_next;
      output_level    <= output_level_next;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= acc;
      end
    end else if (acc) begin
      if (out_valid) skid_valid <= 1'b1;
      else out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) out_data <= skid_data;
      else if (acc) out_data <= {output_level_next, rdata_c};
    end else if (acc) begin
      if (out_valid) skid_data <= {output_level_next, rdata_c};
      else out_data <= {output_level_next, rdata_c};
    end
  end

  // checks
  `ASSERT_NEVER(a_skid_without_out, clk, rst, skid_valid && !out_valid, "skid full with output empty")
  `ASSERT_AT(a_icw1_masks_all, clk, rst, (acc && action == sic_pkg::ACT_WRITE && port == sic_pkg::PORT_CMD && wdata[sic_pkg::ICW1_BIT]) |=> (mask_bits == sic_pkg::MASK_ALL && init_word_count == sic_pkg::IWC_ICW2), "ICW1 did not restart")
  `ASSERT_AT(a_line_irq, clk, rst, (acc && action == sic_pkg::ACT_LINE) |=> (output_level == |(request_bits & ~mask_bits & ~service_bits)), "irq level wrong after line change")

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the simplified interrupt controller: a directed
// opening and weighted random traffic are driven as stream transactions, and
// each result is compared against an in-bench prediction of the controller.
// ----------------------------------------------------------------------------
module tb;

  // codes and command bytes used by the stimulus
  localparam logic [1:0] ACT_NONE    = 2'd3;
  localparam logic [7:0] POLL_HIT    = 8'h80;
  localparam logic [7:0] ICW1_BYTE   = 8'h13;
  localparam logic [7:0] OCW3_POLL   = 8'h0C;
  localparam logic [7:0] OCW3_RD_ISR = 8'h0B;
  localparam logic [7:0] OCW3_RD_IRR = 8'h0A;
  localparam int         RANDOM_OPS  = 950;
  localparam int         TAIL_OPS    = 100;
  localparam int         QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [1:0] action;
    logic       port;
    logic [7:0] wdata;
    logic [2:0] line_no;
    logic       level;
    logic       hold;     // wait for all results before sending
  } bus_op_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
  } pic_result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [sic_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic [sic_pkg::IN_USER_W-1:0]  s_tuser = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [sic_pkg::OUT_DATA_W-1:0] m_tdata;

  simplified_interrupt_controller_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  bus_op_t     op_queue[$];
  pic_result_t result_queue[$];
  bus_op_t     cur_op;
  bit          op_taken = 1'b0;

  // predicted controller state
  logic [7:0]  irr = '0;
  logic [7:0]  isr = '0;
  logic [7:0]  imr = '0;
  logic [1:0]  icw_cnt = sic_pkg::IWC_IDLE;
  logic        poll_armed = 1'b0;
  logic        show_isr = 1'b0;
  logic        irq_level = 1'b0;

  int unsigned err_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned cycle_no = 0;
  int unsigned n_reads = 0, n_writes = 0, n_lines = 0, n_unused = 0;
  int unsigned n_poll_hits = 0, n_results = 0;
  int unsigned gap_left = 0, stall_left = 0;
  logic [7:0]  pred_rdata;
  pic_result_t got;

  function automatic void add_op(logic [1:0] action, logic port, logic [7:0] wdata,
                                 logic [2:0] line_no, logic level, logic hold = 1'b0);
    bus_op_t op;
    op = '{action, port, wdata, line_no, level, hold};
    op_queue.push_back(op);
  endfunction

  // position of the least significant set bit
  function automatic logic [2:0] first_pending(logic [7:0] v);
    logic [2:0] pos;
    bit         found;
    pos = '0;
    found = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (v[i] && !found) begin
        pos = 3'(i);
        found = 1'b1;
      end
    end
    return pos;
  endfunction

  function automatic void refresh_irq();
    irq_level = |(irr & ~imr & ~isr);
  endfunction

  // advance the predicted controller by one transaction
  function automatic void pic_apply(input bus_op_t op, output logic [7:0] rd);
    logic [7:0] ready;
    logic [2:0] hit;
    rd = 8'h00;
    case (op.action)
      sic_pkg::ACT_READ: begin
        n_reads++;
        if (op.port == sic_pkg::PORT_DATA) begin
          rd = imr;
        end else if (poll_armed) begin
          poll_armed = 1'b0;
          ready = irr & ~imr;
          if (ready != 8'h00) begin
            hit = first_pending(ready);
            isr[hit] = 1'b1;
            irr[hit] = 1'b0;
            rd = POLL_HIT | 8'(hit);
            n_poll_hits++;
          end
        end else begin
          rd = show_isr ? isr : irr;
        end
      end
      sic_pkg::ACT_WRITE: begin
        n_writes++;
        if (op.port == sic_pkg::PORT_DATA) begin
          if (icw_cnt != sic_pkg::IWC_IDLE) begin
            icw_cnt = (icw_cnt == sic_pkg::IWC_LAST) ? sic_pkg::IWC_IDLE : icw_cnt + 2'd1;
          end else begin
            imr = op.wdata;
            refresh_irq();
          end
        end else if (op.wdata[sic_pkg::ICW1_BIT]) begin
          icw_cnt = sic_pkg::IWC_ICW2;
          imr = sic_pkg::MASK_ALL;
          irr = '0;
          isr = '0;
          poll_armed = 1'b0;
        end else if (op.wdata[sic_pkg::OCW3_BIT]) begin
          if (op.wdata[sic_pkg::POLL_BIT]) poll_armed = 1'b1;
          if (op.wdata[sic_pkg::RSEL_EN]) show_isr = op.wdata[sic_pkg::RSEL_BIT];
        end else begin
          case (op.wdata[7:5])
            sic_pkg::OCW2_EOI_NS, sic_pkg::OCW2_ROT_NS: isr = isr & (isr - 8'd1);
            sic_pkg::OCW2_EOI_SPEC, sic_pkg::OCW2_ROT_SPEC: isr[op.wdata[2:0]] = 1'b0;
            default: ;
          endcase
          refresh_irq();
        end
      end
      sic_pkg::ACT_LINE: begin
        n_lines++;
        irr[op.line_no] = op.level;
        refresh_irq();
      end
      default: n_unused++;
    endcase
  endfunction

  // idling only outside quiet stretches and never near the end
  function automatic bit idle_allowed();
    return (op_queue.size() >= TAIL_OPS) && ((cycle_no / 128) % 3 != 0);
  endfunction

  // random command bytes with the decode bits forced
  function automatic logic [7:0] rand_ocw2();
    return {3'($urandom), 2'b00, 3'($urandom)};
  endfunction

  function automatic logic [7:0] rand_ocw3(bit poll);
    return {3'($urandom), 2'b01, poll | 1'($urandom), 2'($urandom)};
  endfunction

  task automatic build_directed();
    add_op(sic_pkg::ACT_READ, sic_pkg::PORT_CMD, 8'hFF, 3'd7, 1'b1);
    add_op(sic_pkg::ACT_READ, sic_pkg::PORT_DATA, 8'h00, 3'd0, 1'b0);
    add_op(ACT_NONE, sic_pkg::PORT_DATA, 8'hFF, 3'd7, 1'b1);
    add_op(sic_pkg::ACT_LINE, sic_pkg::PORT_CMD, 8'h00, 3'd0, 1'b1);
    add_op(sic_pkg::ACT_LINE, sic_pkg::PORT_CMD, 8'h00, 3'd7, 1'b1);
    add_op(sic_pkg::ACT_READ, sic_pkg::PORT_CMD, 8'h00, 3'd0, 1'b0);
    add_op(sic_pkg::ACT_WRITE, sic_pkg::PORT_CMD, OCW3_POLL, 3'd0, 1'b0);
    add_op(sic_pkg::ACT_READ, sic_pkg::PORT_CMD, 8'h00, 3'd0, 1'b0);
    add_op(sic_pkg::ACT_WRITE, sic_pkg::PORT_CMD, OCW3_RD_ISR, 3'd0, 1'b0);
    add_op(sic_pkg::ACT_READ, sic_pkg::PORT_CMD, 8'h00, 3'd0, 1'b0);
    add_op(sic_pkg::ACT_WRITE, sic_pkg::PORT_CMD, {sic_pkg::OCW2_EOI_SPEC, 5'd0}, 3'd0, 1'b0);
    add_op(sic_pkg::ACT_WRITE, sic_pkg::PORT_DATA, sic_pkg::MASK_ALL, 3'd0, 1'b0);
    // poll with nothing unmasked
    add_op(sic_pkg::ACT_WRITE, sic_pkg::PORT_CMD, OCW3_POLL, 3'd0, 1'b0);
    add_op(sic_pkg::ACT_READ, sic_pkg::PORT_CMD, 8'h00, 3'd0, 1'b0);
    add_op(sic_pkg::ACT_WRITE, sic_pkg::PORT_DATA, 8'h00, 3'd0, 1'b0);
    add_op(sic_pkg::ACT_WRITE, sic_pkg::PORT_CMD, {sic_pkg::OCW2_EOI_NS, 5'd0}, 3'd0, 1'b0);
    add_op(sic_pkg::ACT_WRITE, sic_pkg::PORT_CMD, {sic_pkg::OCW2_ROT_NS, 5'd0}, 3'd0, 1'b0);
    add_op(sic_pkg::ACT_WRITE, sic_pkg::PORT_CMD, {sic_pkg::OCW2_ROT_SPEC, 5'd7}, 3'd0, 1'b0);
    add_op(sic_pkg::ACT_WRITE, sic_pkg::PORT_CMD, 8'hC0, 3'd0, 1'b0);
    // init sequence with a poll in the middle of it
    add_op(sic_pkg::ACT_WRITE, sic_pkg::PORT_CMD, ICW1_BYTE, 3'd0, 1'b0);
    add_op(sic_pkg::ACT_WRITE, sic_pkg::PORT_CMD, OCW3_POLL, 3'd0, 1'b0);
    add_op(sic_pkg::ACT_LINE, sic_pkg::PORT_CMD, 8'h00, 3'd3, 1'b1);
    add_op(sic_pkg::ACT_READ, sic_pkg::PORT_CMD, 8'h00, 3'd0, 1'b0);
    for (int i = 0; i < 3; i++)
      add_op(sic_pkg::ACT_WRITE, sic_pkg::PORT_DATA, 8'($urandom), 3'd0, 1'b0);
    add_op(sic_pkg::ACT_WRITE, sic_pkg::PORT_DATA, 8'h00, 3'd0, 1'b0);
    add_op(sic_pkg::ACT_WRITE, sic_pkg::PORT_CMD, OCW3_RD_IRR, 3'd0, 1'b0);
    add_op(sic_pkg::ACT_READ, sic_pkg::PORT_CMD, 8'h00, 3'd0, 1'b0);
  endtask

  task automatic build_random();
    int unsigned base;
    int unsigned pick;
    int unsigned words;
    logic        hold_next;
    base = op_queue.size();
    hold_next = 1'b1;
    while (op_queue.size() - base < RANDOM_OPS) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        add_op(sic_pkg::ACT_LINE, 1'($urandom), 8'($urandom), 3'($urandom),
               $urandom_range(0, 9) < 6, hold_next);
      end else if (pick < 38) begin
        add_op(sic_pkg::ACT_WRITE, sic_pkg::PORT_CMD, rand_ocw3(1'b1), 3'($urandom),
               1'($urandom), hold_next);
        add_op(sic_pkg::ACT_READ, sic_pkg::PORT_CMD, 8'($urandom), 3'($urandom),
               1'($urandom));
      end else if (pick < 46) begin
        add_op(sic_pkg::ACT_WRITE, sic_pkg::PORT_CMD, rand_ocw3(1'b0), 3'($urandom),
               1'($urandom), hold_next);
      end else if (pick < 58) begin
        add_op(sic_pkg::ACT_WRITE, sic_pkg::PORT_CMD, rand_ocw2(), 3'($urandom),
               1'($urandom), hold_next);
      end else if (pick < 67) begin
        add_op(sic_pkg::ACT_WRITE, sic_pkg::PORT_DATA, 8'($urandom) & 8'($urandom),
               3'($urandom), 1'($urandom), hold_next);
      end else if (pick < 82) begin
        add_op(sic_pkg::ACT_READ, 1'($urandom), 8'($urandom), 3'($urandom), 1'($urandom),
               hold_next);
      end else if (pick < 86) begin
        // full init sequence followed by a mask
        add_op(sic_pkg::ACT_WRITE, sic_pkg::PORT_CMD, 8'($urandom) | ICW1_BYTE, 3'($urandom),
               1'($urandom), hold_next);
        for (int i = 0; i < 3; i++)
          add_op(sic_pkg::ACT_WRITE, sic_pkg::PORT_DATA, 8'($urandom), 3'd0, 1'b0);
        add_op(sic_pkg::ACT_WRITE, sic_pkg::PORT_DATA, 8'($urandom) & 8'($urandom),
               3'd0, 1'b0);
      end else if (pick < 90) begin
        // broken init: fewer words with other traffic in between
        add_op(sic_pkg::ACT_WRITE, sic_pkg::PORT_CMD, 8'($urandom) | ICW1_BYTE, 3'd0, 1'b0,
               hold_next);
        words = $urandom_range(0, 2);
        for (int i = 0; i < words; i++) begin
          add_op(sic_pkg::ACT_LINE, sic_pkg::PORT_CMD, 8'h00, 3'($urandom), 1'b1);
          add_op(sic_pkg::ACT_WRITE, sic_pkg::PORT_DATA, 8'($urandom), 3'd0, 1'b0);
        end
      end else if (pick < 96) begin
        add_op(sic_pkg::ACT_WRITE, 1'($urandom), 8'($urandom), 3'($urandom), 1'($urandom),
               hold_next);
      end else begin
        add_op(ACT_NONE, 1'($urandom), 8'($urandom), 3'($urandom), 1'($urandom), hold_next);
      end
      hold_next = ($urandom_range(0, 249) == 0);
    end
  endtask

  // driver: next transaction presented at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || op_taken) begin
      op_taken = 1'b0;
      if (gap_left == 0 && idle_allowed() && $urandom_range(0, 5) == 0)
        gap_left = $urandom_range(1, 5);
      if (gap_left != 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (op_queue.size() != 0 &&
                   !(op_queue[0].hold && result_queue.size() != 0)) begin
        cur_op = op_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, cur_op.level, cur_op.line_no, cur_op.wdata};
        s_tuser <= {cur_op.port, cur_op.action};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    if (stall_left == 0 && idle_allowed() && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 5);
    if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor: check results, predict accepted transactions
  always @(posedge clk) begin
    if (!rst) begin
      cycle_no++;
      quiet_cycles++;
      if (m_tvalid && m_tready) begin
        quiet_cycles = 0;
        n_results++;
        got = '{m_tdata[7:0], m_tdata[8]};
        if (result_queue.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result: rdata %02h irq %0b", got.rdata, got.irq);
        end else if (got != result_queue[0]) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch at result %0d: expected rdata %02h irq %0b, got rdata %02h irq %0b",
                     n_results, result_queue[0].rdata, result_queue[0].irq,
                     got.rdata, got.irq);
          void'(result_queue.pop_front());
        end else begin
          void'(result_queue.pop_front());
        end
      end
      if (s_tvalid && s_tready) begin
        quiet_cycles = 0;
        pic_apply(cur_op, pred_rdata);
        result_queue.push_back('{pred_rdata, irq_level});
        op_taken = 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
    $display("FAIL simplified_interrupt_controller_unit");
    $finish;
  end

  // stimulus, reset and end of run
  initial begin
    build_directed();
    build_random();
    repeat (11) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    while (op_queue.size() != 0 || s_tvalid || result_queue.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("covered %0d reads, %0d writes, %0d line changes, %0d unused codes",
             n_reads, n_writes, n_lines, n_unused);
    $display("%0d results checked, %0d poll hits, %0d mismatches",
             n_results, n_poll_hits, err_cnt);
    if (err_cnt == 0) begin
      $display("PASS simplified_interrupt_controller_unit");
    end else begin
      $display("FAIL simplified_interrupt_controller_unit");
    end
    $finish;
  end

endmodule
